/* design/ttd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_pkg
// shared constants for the tap tempo detector
// ----------------------------------------------------------------------------
package ttd_pkg;

	// number of taps kept in the ring (3..16)
	localparam int TAP_COUNT = 4;

	localparam int TS_W   = 32;
	localparam int PER_W  = 16;
	localparam int IDX_W  = $clog2(TAP_COUNT);
	localparam int CNT_W  = $clog2(TAP_COUNT + 1);
	localparam int STEP_W = $clog2(TS_W);

	// reset spacing of the ring entries and the reset period
	localparam int RESET_SPACING = 10;

	// 5*|avg-gap| <= avg is the 20 percent window
	localparam int TOL_MUL = 5;

	// average gap by reciprocal multiply, exact for any span below SPAN_LIM
	localparam int     AVG_DIV  = TAP_COUNT - 1;
	localparam int     DIV_SH   = $clog2(AVG_DIV);
	localparam int     SPAN_W   = PER_W + DIV_SH;
	localparam int     RECIP_SH = SPAN_W + DIV_SH;
	localparam int     RECIP_W  = SPAN_W + 1;
	localparam int     PROD_W   = SPAN_W + RECIP_W;
	localparam longint SPAN_LIM = longint'(AVG_DIV) << PER_W;
	localparam longint RECIP    =
		((longint'(1) << RECIP_SH) + longint'(AVG_DIV) - 1) / longint'(AVG_DIV);

endpackage : ttd_pkg
`default_nettype wire

/* design/tap_tempo_detector_top.sv */
`default_nettype none
// steps: an accepted tap passes ST_OLD, ST_DIVA and ST_CHK; a rejected average goes on to
// ST_FIN, a failed gap walks ST_WALK first, a lock walks ST_WALK and then ST_DIVM
// taps: one at a time, next tap taken the cycle after the result loads;
// average by a reciprocal multiply, a lock adds the 1-bit-per-cycle
// restoring divider for tap mod period; a waiting result stalls the last step
// reset: arst_n asynchronous active low; ring entry i = 10*i, period 10, offset 0
// ----------------------------------------------------------------------------
// tap_tempo_detector_top
// tempo estimator: averages the gaps of the last taps and locks a period
// and beat offset when every gap lies within 20 percent of the average
// ----------------------------------------------------------------------------
module tap_tempo_detector_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [ttd_pkg::TS_W-1:0]  tap_time_ms,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           locked,
	output logic [ttd_pkg::PER_W-1:0]      beat_period_ms,
	output logic [ttd_pkg::PER_W-1:0]      beat_offset_ms
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OLD,
		ST_DIVA,
		ST_CHK,
		ST_WALK,
		ST_DIVM,
		ST_FIN
	} state_t;

	localparam int TS_W   = ttd_pkg::TS_W;
	localparam int PER_W  = ttd_pkg::PER_W;
	localparam int IDX_W  = ttd_pkg::IDX_W;
	localparam int CNT_W  = ttd_pkg::CNT_W;
	localparam int STW    = ttd_pkg::STEP_W;
	localparam int SPAN_W = ttd_pkg::SPAN_W;
	localparam int PROD_W = ttd_pkg::PROD_W;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ttd_pkg::TAP_COUNT - 1);
	localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(ttd_pkg::TAP_COUNT - 1);
	localparam logic [STW-1:0]    LAST_STEP = STW'(TS_W - 1);
	localparam logic [TS_W-1:0]   SPAN_LIM  = TS_W'(ttd_pkg::SPAN_LIM);
	localparam logic [PROD_W-1:0] RECIP     = PROD_W'(ttd_pkg::RECIP);

	state_t                state_q;
	logic [TS_W-1:0]       ring_q [ttd_pkg::TAP_COUNT];
	logic [IDX_W-1:0]      newest_q;
	logic [IDX_W-1:0]      walk_idx_q;
	logic [CNT_W-1:0]      walk_cnt_q;
	logic [TS_W-1:0]       now_q;
	logic [TS_W-1:0]       prev_q;
	logic [PER_W-1:0]      avg_q;
	logic                  pass_q;
	logic                  ok_q;
	logic [TS_W-1:0]       dvd_q;
	logic [PER_W-1:0]      rem_q;
	logic [PER_W-1:0]      dsr_q;
	logic [STW-1:0]        step_q;
	logic                  out_valid_q;
	logic                  locked_q;
	logic [PER_W-1:0]      held_period_q;
	logic [PER_W-1:0]      held_offset_q;

	logic [IDX_W-1:0]      rd_idx;
	logic [TS_W-1:0]       rd_data;
	logic [IDX_W-1:0]      newest_nx;
	logic [IDX_W-1:0]      oldest;
	logic [IDX_W-1:0]      walk_idx_nx;
	logic [PER_W:0]        rem_sh;
	logic                  div_ge;
	logic [PER_W-1:0]      rem_nx;
	logic [PROD_W-1:0]     avg_prod;
	logic [PER_W-1:0]      avg_quo;
	logic [TS_W-1:0]       gap;
	logic [TS_W-1:0]       diff;
	logic [TS_W+2:0]       diff5;
	logic                  gap_ok;
	logic                  emit;

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign locked         = locked_q;
	assign beat_period_ms = held_period_q;
	assign beat_offset_ms = held_offset_q;

	assign newest_nx   = (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;
	assign oldest      = (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;
	assign walk_idx_nx = (walk_idx_q == LAST_IDX) ? '0 : walk_idx_q + 1'b1;

	// one ring entry read per cycle
	assign rd_idx  = (state_q == ST_OLD) ? oldest : walk_idx_q;
	assign rd_data = ring_q[rd_idx];

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[TS_W-1]};
	assign div_ge = (rem_sh >= {1'b0, dsr_q});
	assign rem_nx = div_ge ? PER_W'(rem_sh - {1'b0, dsr_q}) : PER_W'(rem_sh);

	// span/(TAP_COUNT-1) by multiplying with the rounded-up reciprocal
	assign avg_prod = PROD_W'(dvd_q[SPAN_W-1:0]) * RECIP;
	assign avg_quo  = avg_prod[ttd_pkg::RECIP_SH +: PER_W];

	// gap window test, 5*diff by shift and add
	assign gap    = rd_data - prev_q;
	assign diff   = (gap > {16'd0, avg_q}) ? gap - {16'd0, avg_q} : {16'd0, avg_q} - gap;
	assign diff5  = {1'b0, diff, 2'b00} + {3'b000, diff};
	assign gap_ok = (diff5 <= {{(TS_W+3-PER_W){1'b0}}, avg_q});

	assign emit = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			for (int i = 0; i < ttd_pkg::TAP_COUNT; i++) begin
				ring_q[i] <= TS_W'(i * ttd_pkg::RESET_SPACING);
			end
			newest_q      <= LAST_IDX;
			walk_idx_q    <= '0;
			walk_cnt_q    <= '0;
			pass_q        <= 1'b0;
			ok_q          <= 1'b0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
			locked_q      <= 1'b0;
			held_period_q <= PER_W'(ttd_pkg::RESET_SPACING);
			held_offset_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						newest_q         <= newest_nx;
						ring_q[newest_nx] <= tap_time_ms;
						now_q            <= tap_time_ms;
						state_q          <= ST_OLD;
					end
				end
				ST_OLD: begin
					dvd_q   <= now_q - rd_data;
					state_q <= ST_DIVA;
				end
				ST_DIVA: begin
					// a span at or past the limit already has high bits set
					if (dvd_q < SPAN_LIM) begin
						dvd_q <= TS_W'(avg_quo);
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// zero or oversized average never locks
					avg_q      <= dvd_q[PER_W-1:0];
					walk_idx_q <= oldest;
					walk_cnt_q <= '0;
					pass_q     <= 1'b1;
					if ((dvd_q != '0) && (dvd_q[TS_W-1:PER_W] == '0)) begin
						state_q <= ST_WALK;
					end else begin
						ok_q    <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_WALK: begin
					// oldest to newest, first read only primes prev
					prev_q     <= rd_data;
					walk_idx_q <= walk_idx_nx;
					walk_cnt_q <= walk_cnt_q + 1'b1;
					if ((walk_cnt_q != '0) && !gap_ok) begin
						pass_q <= 1'b0;
					end
					if (walk_cnt_q == LAST_CNT) begin
						if (pass_q && gap_ok) begin
							dvd_q   <= now_q;
							rem_q   <= '0;
							dsr_q   <= avg_q;
							step_q  <= '0;
							state_q <= ST_DIVM;
						end else begin
							ok_q    <= 1'b0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIVM: begin
					dvd_q  <= {dvd_q[TS_W-2:0], div_ge};
					rem_q  <= rem_nx;
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						ok_q    <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (emit) begin
						locked_q <= ok_q;
						if (ok_q) begin
							held_period_q <= avg_q;
							held_offset_q <= avg_q - rem_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule : tap_tempo_detector_top
`default_nettype wire
